// ===== design/assert_macros.svh =====
// Assertion macros shared by the conditioner RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge outside reset.
`define GAC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition never holds on a rising clk edge outside reset.
`define GAC_NEVER(lbl, cond, msg) \
	`GAC_ASSERT(lbl, !(cond), msg)

`endif

// ===== design/gac_pkg.sv =====
// Shared types and constants of the gamepad ADC conditioner.
`timescale 1ns / 1ps
package gac_pkg;

	localparam int BUTTON_COUNT = 6;
	localparam int MV_W         = 12;
	localparam int THR_W        = 10;
	localparam int MAG_W        = 15;
	localparam int NUM_W        = 27;
	localparam int DIV_STEPS    = 16;
	localparam int DIV_CNT_W    = 4;
	localparam int QUEUE_DEPTH  = 2;
	localparam int QPTR_W       = 1;

	localparam logic [MAG_W-1:0] FULL_SCALE = 15'd32767;
	localparam logic signed [15:0] DPAD_POS = 16'sd18000;
	localparam logic signed [15:0] DPAD_NEG = -16'sd18000;
	localparam logic [3:0] KEY_DPAD_BASE = 4'd6;
	localparam logic [3:0] CH_BUTTON0    = 4'd6;

	localparam int MODE_LSWAP = 4;
	localparam int MODE_RSWAP = 5;
	localparam int MODE_DPAD  = 6;

	typedef enum logic [3:0] {
		REG_STICK_MIN  = 4'd0,
		REG_STICK_MAX  = 4'd1,
		REG_DEAD_LOW   = 4'd2,
		REG_DEAD_HIGH  = 4'd3,
		REG_TRIG_MIN   = 4'd4,
		REG_TRIG_MAX   = 4'd5,
		REG_MODE       = 4'd6,
		REG_BUTTON_THR = 4'd7
	} reg_idx_t;

	typedef struct packed {
		logic [MV_W-1:0] stick_min;
		logic [MV_W-1:0] stick_max;
		logic [MV_W-1:0] dead_low;
		logic [MV_W-1:0] dead_high;
		logic [MV_W-1:0] trig_min;
		logic [MV_W-1:0] trig_max;
		logic [6:0]      mode;
		logic [59:0]     btn_thr;
	} cfg_t;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_STICK,
		OP_TRIGGER,
		OP_BUTTON
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [3:0]       target;
		logic             left;
		logic             ch_x;
		logic             direct;
		logic             neg;
		logic [MAG_W-1:0] mag;
		logic [NUM_W-1:0] num;
		logic [MV_W-1:0]  den;
	} job_t;

	typedef struct packed {
		logic               kind;
		logic [3:0]         target;
		logic signed [15:0] value;
		logic               last;
	} event_t;

endpackage

// ===== design/gac_cfg.sv =====
// Configuration register file of the conditioner.
`timescale 1ns / 1ps
module gac_cfg import gac_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [3:0]  wr_index,
	input  logic [59:0] wr_data,
	output cfg_t        cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.stick_min <= 12'd250;
			cfg_q.stick_max <= 12'd1550;
			cfg_q.dead_low  <= 12'd790;
			cfg_q.dead_high <= 12'd1010;
			cfg_q.trig_min  <= 12'd50;
			cfg_q.trig_max  <= 12'd800;
			cfg_q.mode      <= 7'd0;
			cfg_q.btn_thr   <= 60'd90160039460946000;
		end else if (wr_en) begin
			unique case (reg_idx_t'(wr_index))
				REG_STICK_MIN:  cfg_q.stick_min <= wr_data[MV_W-1:0];
				REG_STICK_MAX:  cfg_q.stick_max <= wr_data[MV_W-1:0];
				REG_DEAD_LOW:   cfg_q.dead_low  <= wr_data[MV_W-1:0];
				REG_DEAD_HIGH:  cfg_q.dead_high <= wr_data[MV_W-1:0];
				REG_TRIG_MIN:   cfg_q.trig_min  <= wr_data[MV_W-1:0];
				REG_TRIG_MAX:   cfg_q.trig_max  <= wr_data[MV_W-1:0];
				REG_MODE:       cfg_q.mode      <= wr_data[6:0];
				REG_BUTTON_THR: cfg_q.btn_thr   <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== design/gac_front.sv =====
// Front end: accept ADC samples and turn them into jobs for the back end.
`timescale 1ns / 1ps
module gac_front import gac_pkg::*; (
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [3:0]      channel,
	input  logic [MV_W-1:0] reading_mv,
	input  logic            read_ok,
	input  cfg_t            cfg,
	input  logic            q_full,
	output logic            q_push,
	output job_t            q_job
);

	function automatic logic [MV_W-1:0] clamp_mv(input logic [MV_W-1:0] v,
			input logic [MV_W-1:0] lo, input logic [MV_W-1:0] hi);
		logic [MV_W-1:0] t;
		t = (v < lo) ? lo : v;
		return (t > hi) ? hi : t;
	endfunction

	logic [MV_W-1:0]  suv, tuv, sx, tabs, sdabs, tdabs;
	logic [MV_W:0]    sdsig, tdiff, tdsig;
	logic             below, above, sneg_raw, inv, swap;
	logic [3:0]       k;
	logic [THR_W-1:0] thr;

	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full;

	always_comb begin
		suv      = clamp_mv(reading_mv, cfg.stick_min, cfg.stick_max);
		below    = suv < cfg.dead_low;
		above    = suv > cfg.dead_high;
		if (below) begin
			sx       = cfg.dead_low - suv;
			sdsig    = {1'b0, cfg.dead_low} - {1'b0, cfg.stick_min};
			sneg_raw = 1'b1;
		end else begin
			sx       = suv - cfg.dead_high;
			sdsig    = {1'b0, cfg.stick_max} - {1'b0, cfg.dead_high};
			sneg_raw = 1'b0;
		end
		sdabs = sdsig[MV_W] ? MV_W'(-sdsig) : sdsig[MV_W-1:0];
		inv   = cfg.mode[channel[1:0]];
		swap  = channel[1] ? cfg.mode[MODE_RSWAP] : cfg.mode[MODE_LSWAP];

		tuv   = clamp_mv(reading_mv, cfg.trig_min, cfg.trig_max);
		tdiff = {1'b0, tuv} - {1'b0, cfg.trig_min};
		tabs  = tdiff[MV_W] ? MV_W'(-tdiff) : tdiff[MV_W-1:0];
		tdsig = {1'b0, cfg.trig_max} - {1'b0, cfg.trig_min};
		tdabs = tdsig[MV_W] ? MV_W'(-tdsig) : tdsig[MV_W-1:0];

		k   = channel - CH_BUTTON0;
		thr = THR_W'(cfg.btn_thr >> (THR_W * int'(k[2:0])));

		q_job        = '0;
		q_job.op     = OP_NONE;
		q_job.direct = 1'b1;
		case (channel) inside
			[4'd0:4'd3]: begin
				q_job.op     = OP_STICK;
				q_job.target = swap ? (channel ^ 4'd1) : channel;
				q_job.left   = !channel[1];
				q_job.ch_x   = !channel[0];
				if (!read_ok || (!below && !above)) begin
					q_job.mag = '0;
				end else if (sdabs == '0) begin
					q_job.mag = FULL_SCALE;
					q_job.neg = sneg_raw ^ inv;
				end else begin
					q_job.direct = 1'b0;
					q_job.num    = {sx, 15'd0} - NUM_W'(sx);
					q_job.den    = sdabs;
					q_job.neg    = sneg_raw ^ sdsig[MV_W] ^ inv;
				end
			end
			4'd4, 4'd5: begin
				if (read_ok) begin
					q_job.op     = OP_TRIGGER;
					q_job.target = channel;
					if (tdabs == '0) begin
						q_job.mag = FULL_SCALE;
					end else begin
						q_job.direct = 1'b0;
						q_job.num    = {tabs, 15'd0} - NUM_W'(tabs);
						q_job.den    = tdabs;
					end
				end
			end
			[4'd6:4'd11]: begin
				if (read_ok && int'(k) < BUTTON_COUNT) begin
					q_job.op     = OP_BUTTON;
					q_job.target = k;
					q_job.mag    = MAG_W'(reading_mv < {2'b00, thr});
				end
			end
			default: ;
		endcase
	end

endmodule

// ===== design/gac_fifo.sv =====
// Two-entry job queue between the front and back ends.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module gac_fifo import gac_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_data,
	output logic full,
	input  logic pop,
	output job_t pop_data,
	output logic empty
);

	job_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]   cnt_q;

	assign full     = cnt_q == (QPTR_W+1)'(QUEUE_DEPTH);
	assign empty    = cnt_q == '0;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	`GAC_NEVER(a_push_full, push && full, "job pushed into full queue")
	`GAC_NEVER(a_pop_empty, pop && empty, "job popped from empty queue")

endmodule

// ===== design/gac_back.sv =====
// Back end: dpad release, shared divider, dpad key tracking and event output.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module gac_back import gac_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  cfg_t   cfg,
	input  logic   q_empty,
	input  job_t   q_job,
	output logic   q_pop,
	output logic   ev_valid,
	input  logic   ev_ready,
	output event_t ev
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_REL,
		S_DIV,
		S_RES,
		S_KEY,
		S_AXIS
	} state_t;

	state_t               st_q;
	job_t                 job_q;
	logic [3:0]           held_q, rel_q;
	logic [NUM_W-1:0]     rem_q, dsh_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_STEPS-1:0] quo_q;
	logic signed [15:0]   val_q;
	logic [1:0]           pend_q, nowb_q;
	logic [1:0]           hb_q;
	logic                 out_valid_q;
	event_t               out_q;

	logic               dpad, out_free, ge;
	logic [NUM_W:0]     diff;
	logic [1:0]         rel_b, hb;
	logic [3:0]         rel_rest;
	logic [MAG_W-1:0]   mag_now;
	logic [15:0]        mag16;
	logic signed [15:0] sval;
	logic               now_lo, now_hi;

	assign dpad     = cfg.mode[MODE_DPAD];
	assign out_free = !out_valid_q || ev_ready;
	assign q_pop    = (st_q == S_IDLE) && !q_empty;
	assign ev_valid = out_valid_q;
	assign ev       = out_q;

	assign diff = {1'b0, rem_q} - {1'b0, dsh_q};
	assign ge   = !diff[NUM_W];

	assign rel_rest = rel_q & (rel_q - 4'd1);
	assign hb       = job_q.ch_x ? 2'd2 : 2'd0;

	always_comb begin
		if (rel_q[0]) begin
			rel_b = 2'd0;
		end else if (rel_q[1]) begin
			rel_b = 2'd1;
		end else if (rel_q[2]) begin
			rel_b = 2'd2;
		end else begin
			rel_b = 2'd3;
		end
		if (job_q.direct) begin
			mag_now = job_q.mag;
		end else if (quo_q[DIV_STEPS-1]) begin
			mag_now = FULL_SCALE;
		end else begin
			mag_now = quo_q[MAG_W-1:0];
		end
		mag16  = {1'b0, mag_now};
		sval   = job_q.neg ? $signed(16'(-mag16)) : $signed(mag16);
		now_lo = sval < DPAD_NEG;
		now_hi = sval > DPAD_POS;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			job_q       <= '0;
			held_q      <= '0;
			rel_q       <= '0;
			rem_q       <= '0;
			dsh_q       <= '0;
			cnt_q       <= '0;
			quo_q       <= '0;
			val_q       <= '0;
			pend_q      <= '0;
			nowb_q      <= '0;
			hb_q        <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (ev_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (st_q)
				S_IDLE: begin
					if (!q_empty) begin
						job_q <= q_job;
						if (!dpad && held_q != '0) begin
							rel_q  <= held_q;
							held_q <= '0;
						end else begin
							rel_q <= '0;
						end
						st_q <= S_REL;
					end
				end
				S_REL: begin
					if (rel_q != '0) begin
						if (out_free) begin
							out_valid_q   <= 1'b1;
							out_q.kind    <= 1'b1;
							out_q.target  <= KEY_DPAD_BASE + 4'(rel_b);
							out_q.value   <= '0;
							out_q.last    <= (rel_rest == '0) && (job_q.op == OP_NONE);
							rel_q         <= rel_rest;
						end
					end else if (job_q.op == OP_NONE) begin
						st_q <= S_IDLE;
					end else if (job_q.direct) begin
						st_q <= S_RES;
					end else begin
						rem_q <= job_q.num;
						dsh_q <= {job_q.den, 15'd0};
						cnt_q <= DIV_CNT_W'(DIV_STEPS - 1);
						quo_q <= '0;
						st_q  <= S_DIV;
					end
				end
				S_DIV: begin
					if (ge) begin
						rem_q <= diff[NUM_W-1:0];
					end
					quo_q <= {quo_q[DIV_STEPS-2:0], ge};
					dsh_q <= dsh_q >> 1;
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						st_q <= S_RES;
					end
				end
				S_RES: begin
					if (dpad && job_q.op == OP_STICK && job_q.left) begin
						pend_q           <= {now_hi != held_q[hb + 2'd1], now_lo != held_q[hb]};
						nowb_q           <= {now_hi, now_lo};
						hb_q             <= hb;
						held_q[hb]       <= now_lo;
						held_q[hb + 2'd1] <= now_hi;
						val_q            <= '0;
						if (now_hi != held_q[hb + 2'd1] || now_lo != held_q[hb]) begin
							st_q <= S_KEY;
						end else begin
							st_q <= S_AXIS;
						end
					end else begin
						val_q <= sval;
						st_q  <= S_AXIS;
					end
				end
				S_KEY: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_q.kind   <= 1'b1;
						out_q.last   <= 1'b0;
						if (pend_q[0]) begin
							out_q.target <= KEY_DPAD_BASE + 4'(hb_q);
							out_q.value  <= 16'(nowb_q[0]);
							pend_q[0]    <= 1'b0;
							if (!pend_q[1]) begin
								st_q <= S_AXIS;
							end
						end else begin
							out_q.target <= KEY_DPAD_BASE + 4'(hb_q) + 4'd1;
							out_q.value  <= 16'(nowb_q[1]);
							pend_q[1]    <= 1'b0;
							st_q         <= S_AXIS;
						end
					end
				end
				S_AXIS: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_q.kind   <= job_q.op == OP_BUTTON;
						out_q.target <= job_q.target;
						out_q.value  <= val_q;
						out_q.last   <= 1'b1;
						st_q         <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	`GAC_ASSERT(a_key_pending, st_q == S_KEY |-> pend_q != 2'b00, "key state without pending key")
	`GAC_ASSERT(a_rel_clear, (st_q == S_REL && rel_q != '0) |-> held_q == '0,
		"dpad keys still held during release")
	`GAC_NEVER(a_val_range, out_valid_q && out_q.value == 16'sh8000, "axis value out of range")

endmodule

// ===== design/gamepad_adc_conditioner.sv =====
// Top level of the gamepad ADC conditioner.
`timescale 1ns / 1ps
// Takes one ADC sample per input word (channel, millivolt reading, read-ok flag)
// and emits up to five event words: stick and trigger axis values, button key
// states and, in dpad mode, dpad key changes; tlast marks the final event of a
// sample. The front end classifies a sample in the cycle it is accepted and
// queues it in a two-entry queue, so sampling continues while the back end
// works. The back end handles one sample at a time. A stick or trigger value
// that needs scaling goes through the shared 16-step restoring divider; each
// dpad release or key change adds an event word, and a stalled output holds
// the back end until the word is taken.
// Write configuration only while no sample is in flight.
module gamepad_adc_conditioner import gac_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // channel[3:0], reading_mv[15:4], read_ok[16]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // target[3:0], value[19:4]
	output logic        m_axis_tuser,   // event_kind[0]
	output logic        m_axis_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_index,
	input  logic [59:0] cfg_data
);

	cfg_t   cfg;
	job_t   push_job, pop_job;
	logic   push, pop, full, empty;
	event_t ev;

	assign cfg_ready = 1'b1;

	gac_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	gac_front u_front (
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.channel    (s_axis_tdata[3:0]),
		.reading_mv (s_axis_tdata[15:4]),
		.read_ok    (s_axis_tdata[16]),
		.cfg        (cfg),
		.q_full     (full),
		.q_push     (push),
		.q_job      (push_job)
	);

	gac_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_job),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_job),
		.empty     (empty)
	);

	gac_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.q_empty  (empty),
		.q_job    (pop_job),
		.q_pop    (pop),
		.ev_valid (m_axis_tvalid),
		.ev_ready (m_axis_tready),
		.ev       (ev)
	);

	assign m_axis_tdata = {4'd0, ev.value, ev.target};
	assign m_axis_tuser = ev.kind;
	assign m_axis_tlast = ev.last;

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for gamepad_adc_conditioner: directed and random samples, scoreboard.
`timescale 1ns / 1ps
module tb_top;
	import gac_pkg::*;

	localparam longint AXIS_FS = 32767;
	localparam longint DPAD_TRIP = 18000;
	localparam int SETTLE_CYCLES = 40;
	localparam int QUIET_LIMIT = 2000;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int PHASE_ITEMS = 25;
	localparam int PHASES = 10;
	localparam logic [59:0] RESET_THR = 60'd90160039460946000;

	localparam logic [3:0] CH_LX = 4'd0;
	localparam logic [3:0] CH_LY = 4'd1;
	localparam logic [3:0] CH_RX = 4'd2;
	localparam logic [3:0] CH_RY = 4'd3;
	localparam logic [3:0] CH_TRIG_L = 4'd4;
	localparam logic [3:0] CH_TRIG_R = 4'd5;
	localparam logic [3:0] CH_UNUSED = 4'd12;
	localparam logic [3:0] CH_TOP = 4'd15;

	localparam logic EV_AXIS = 1'b0;
	localparam logic EV_KEY = 1'b1;

	localparam int DPAD_UP = 0;
	localparam int DPAD_DOWN = 1;
	localparam int DPAD_LEFT = 2;
	localparam int DPAD_RIGHT = 3;

	typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	class event_board;
		cfg_t       cfg;
		logic [3:0] dpad_held;
		event_t     due[$];
		int         errors;
		int         samples;
		int         events;

		function new();
			cfg.stick_min = 12'd250;
			cfg.stick_max = 12'd1550;
			cfg.dead_low = 12'd790;
			cfg.dead_high = 12'd1010;
			cfg.trig_min = 12'd50;
			cfg.trig_max = 12'd800;
			cfg.mode = 7'd0;
			cfg.btn_thr = RESET_THR;
			dpad_held = '0;
			errors = 0;
			samples = 0;
			events = 0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [59:0] v);
			case (idx)
			REG_STICK_MIN:  cfg.stick_min = v[11:0];
			REG_STICK_MAX:  cfg.stick_max = v[11:0];
			REG_DEAD_LOW:   cfg.dead_low = v[11:0];
			REG_DEAD_HIGH:  cfg.dead_high = v[11:0];
			REG_TRIG_MIN:   cfg.trig_min = v[11:0];
			REG_TRIG_MAX:   cfg.trig_max = v[11:0];
			REG_MODE:       cfg.mode = v[6:0];
			REG_BUTTON_THR: cfg.btn_thr = v;
			default: ;
			endcase
		endfunction

		function void push_event(logic kind, logic [3:0] tgt, longint val);
			event_t e;
			e.kind = kind;
			e.target = tgt;
			e.value = 16'(val);
			e.last = 1'b0;
			due.push_back(e);
		endfunction

		function longint clip(longint v, longint lo);
			if (v < lo) return lo;
			if (v > AXIS_FS) return AXIS_FS;
			return v;
		endfunction

		function longint scale_stick(longint uv, bit inv);
			longint lo, hi, dlo, dhi, d, v;
			lo = cfg.stick_min;
			hi = cfg.stick_max;
			dlo = cfg.dead_low;
			dhi = cfg.dead_high;
			if (uv < lo) uv = lo;
			if (uv > hi) uv = hi;
			if (uv >= dlo && uv <= dhi) return 0;
			if (uv < dlo) begin
				d = dlo - lo;
				v = (d == 0) ? -AXIS_FS : ((uv - dlo) * AXIS_FS) / d;
			end else begin
				d = hi - dhi;
				v = (d == 0) ? AXIS_FS : ((uv - dhi) * AXIS_FS) / d;
			end
			if (inv) v = -v;
			return clip(v, -AXIS_FS);
		endfunction

		function longint scale_trigger(longint uv);
			longint lo, hi, d, v;
			lo = cfg.trig_min;
			hi = cfg.trig_max;
			if (uv < lo) uv = lo;
			if (uv > hi) uv = hi;
			d = hi - lo;
			v = (d == 0) ? AXIS_FS : ((uv - lo) * AXIS_FS) / d;
			return clip(v, 0);
		endfunction

		function void key_change(int b, bit now);
			if (now != dpad_held[b]) begin
				push_event(EV_KEY, KEY_DPAD_BASE + 4'(b), now);
				dpad_held[b] = now;
			end
		endfunction

		function void note_sample(logic [3:0] ch, logic [11:0] mv, logic ok);
			int         first;
			int         k;
			bit         dpad;
			longint     v;
			logic [3:0] tgt;
			first = due.size();
			dpad = cfg.mode[MODE_DPAD];
			samples++;
			if (!dpad && dpad_held != 0) begin
				for (int b = 0; b < 4; b++)
					if (dpad_held[b]) push_event(EV_KEY, KEY_DPAD_BASE + 4'(b), 0);
				dpad_held = '0;
			end
			if (ch <= CH_RY) begin
				v = ok ? scale_stick(mv, cfg.mode[ch]) : 0;
				if (dpad && ch <= CH_LY) begin
					if (ch == CH_LY) begin
						key_change(DPAD_UP, v < -DPAD_TRIP);
						key_change(DPAD_DOWN, v > DPAD_TRIP);
					end else begin
						key_change(DPAD_LEFT, v < -DPAD_TRIP);
						key_change(DPAD_RIGHT, v > DPAD_TRIP);
					end
					v = 0;
				end
				tgt = ch;
				if ((ch <= CH_LY) ? cfg.mode[MODE_LSWAP] : cfg.mode[MODE_RSWAP])
					tgt[0] = ~tgt[0];
				push_event(EV_AXIS, tgt, v);
			end else if (ch <= CH_TRIG_R) begin
				if (ok) push_event(EV_AXIS, ch, scale_trigger(mv));
			end else if (ch < CH_UNUSED) begin
				k = ch - CH_BUTTON0;
				if (ok && k < BUTTON_COUNT)
					push_event(EV_KEY, 4'(k), mv < cfg.btn_thr[THR_W * k +: THR_W]);
			end
			if (due.size() > first) due[due.size() - 1].last = 1'b1;
		endfunction

		function void check_event(logic kind, logic [3:0] tgt, logic signed [15:0] val,
				logic last);
			event_t e;
			if (due.size() == 0) begin
				$error("unexpected event: event_kind %0d target %0d value %0d last_event %0d",
					kind, tgt, val, last);
				errors++;
				return;
			end
			e = due.pop_front();
			events++;
			if (kind !== e.kind) begin
				$error("event_kind: expected %0d, got %0d", e.kind, kind);
				errors++;
			end
			if (tgt !== e.target) begin
				$error("target: expected %0d, got %0d", e.target, tgt);
				errors++;
			end
			if (val !== e.value) begin
				$error("value: expected %0d, got %0d", e.value, val);
				errors++;
			end
			if (last !== e.last) begin
				$error("last_event: expected %0d, got %0d", e.last, last);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [23:0] m_axis_tdata;
	logic        m_axis_tuser;
	logic        m_axis_tlast;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [3:0]  cfg_index;
	logic [59:0] cfg_data;

	event_board board = new();
	int         send_idle_pct = 0;
	int         recv_stall_pct = 0;
	int         hold_len = 0;
	int         quiet_cycles = 0;
	int         settings = 0;

	gamepad_adc_conditioner dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		m_axis_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_len > 0) begin
				m_axis_tready <= 1'b0;
				repeat (hold_len) @(posedge clk);
				hold_len = 0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			board.check_event(m_axis_tuser, m_axis_tdata[3:0], m_axis_tdata[19:4],
				m_axis_tlast);
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$error("no word moved for %0d cycles, %0d events outstanding",
				quiet_cycles, board.due.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic set_idle(input idle_mode_t m);
		case (m)
		IDLE_NONE: begin send_idle_pct = 0; recv_stall_pct = 0; end
		IDLE_SEND: begin send_idle_pct = 82; recv_stall_pct = 0; end
		IDLE_RECV: begin send_idle_pct = 0; recv_stall_pct = 82; end
		default: begin send_idle_pct = 11; recv_stall_pct = 11; end
		endcase
	endtask

	task automatic send_sample(input logic [3:0] ch, input logic [11:0] mv, input logic ok);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {7'b0, ok, mv, ch};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		board.note_sample(ch, mv, ok);
	endtask

	// hold input off until every event is out, then let queued no-event samples finish
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (board.due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apply_config(input cfg_t c);
		reg_idx_t    r;
		logic [59:0] v;
		for (int i = REG_STICK_MIN; i <= REG_BUTTON_THR; i++) begin
			r = reg_idx_t'(i);
			case (r)
			REG_STICK_MIN:  v = 60'(c.stick_min);
			REG_STICK_MAX:  v = 60'(c.stick_max);
			REG_DEAD_LOW:   v = 60'(c.dead_low);
			REG_DEAD_HIGH:  v = 60'(c.dead_high);
			REG_TRIG_MIN:   v = 60'(c.trig_min);
			REG_TRIG_MAX:   v = 60'(c.trig_max);
			REG_MODE:       v = 60'(c.mode);
			default:        v = c.btn_thr;
			endcase
			cfg_valid <= 1'b1;
			cfg_index <= r;
			cfg_data <= v;
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
			board.set_reg(r, v);
		end
		cfg_valid <= 1'b0;
		settings++;
	endtask

	function automatic cfg_t make_cfg(int smin, int smax, int dlo, int dhi, int tmin,
			int tmax, int mode, logic [59:0] thr);
		cfg_t c;
		c.stick_min = 12'(smin);
		c.stick_max = 12'(smax);
		c.dead_low = 12'(dlo);
		c.dead_high = 12'(dhi);
		c.trig_min = 12'(tmin);
		c.trig_max = 12'(tmax);
		c.mode = 7'(mode);
		c.btn_thr = thr;
		return c;
	endfunction

	function automatic cfg_t rand_cfg(bit wild, bit dpad);
		cfg_t c;
		int   a, b, d, e, t;
		if (wild) begin
			c = make_cfg($urandom_range(4095), $urandom_range(4095), $urandom_range(4095),
				$urandom_range(4095), $urandom_range(4095), $urandom_range(4095), 0, '0);
		end else begin
			a = $urandom_range(1500);
			b = a + $urandom_range(800);
			d = b + $urandom_range(600);
			e = d + $urandom_range(1000);
			t = $urandom_range(2000);
			c = make_cfg(a, e, b, d, t, t + $urandom_range(2000), 0, '0);
		end
		c.mode = 7'($urandom);
		c.mode[MODE_DPAD] = dpad;
		c.btn_thr = 60'({$urandom, $urandom});
		return c;
	endfunction

	task automatic run_phase(input cfg_t c, input idle_mode_t m, input int hold);
		logic [3:0] ch;
		logic [11:0] mv;
		logic       ok;
		int         btn;
		drain();
		apply_config(c);
		set_idle(m);
		hold_len = hold;
		for (int i = 0; i < PHASE_ITEMS; i++) begin
			if ($urandom_range(9) < 6)
				ch = c.mode[MODE_DPAD] ? 4'($urandom_range(1)) : 4'($urandom_range(3));
			else
				ch = 4'($urandom_range(15));
			btn = $urandom_range(BUTTON_COUNT - 1);
			case ($urandom_range(6))
			0: mv = c.stick_min;
			1: mv = c.stick_max;
			2: mv = c.dead_low;
			3: mv = c.dead_high;
			4: mv = c.trig_min;
			5: mv = c.trig_max;
			default: mv = {2'b00, c.btn_thr[THR_W * btn +: THR_W]};
			endcase
			if ($urandom_range(1))
				mv = 12'($urandom);
			else
				mv = mv + 12'($urandom_range(6)) - 12'd3;
			ok = ($urandom_range(9) != 0);
			send_sample(ch, mv, ok);
		end
	endtask

	initial begin
		cfg_t c;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_STICK_MIN;
		cfg_data <= '0;
		arst_n <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_idle(IDLE_NONE);
		send_sample(CH_LX, 12'd0, 1'b1);
		send_sample(CH_LX, 12'd4095, 1'b1);
		send_sample(CH_LY, 12'd900, 1'b1);
		send_sample(CH_RX, 12'd500, 1'b1);
		send_sample(CH_RY, 12'd4095, 1'b0);
		send_sample(CH_TRIG_L, 12'd0, 1'b1);
		send_sample(CH_TRIG_R, 12'd4095, 1'b1);
		send_sample(CH_TRIG_L, 12'd425, 1'b1);
		send_sample(CH_TRIG_R, 12'd100, 1'b0);
		send_sample(CH_BUTTON0, 12'd0, 1'b1);
		send_sample(CH_BUTTON0 + 4'd5, 12'd1023, 1'b1);
		send_sample(CH_BUTTON0 + 4'd3, 12'd4095, 1'b0);
		send_sample(CH_UNUSED, 12'd100, 1'b1);
		send_sample(CH_TOP, 12'd4095, 1'b1);

		// dpad on, both sides swapped, RX inverted
		drain();
		c = make_cfg(250, 1550, 790, 1010, 50, 800,
			(1 << MODE_DPAD) | (1 << MODE_LSWAP) | (1 << MODE_RSWAP) | 4, RESET_THR);
		apply_config(c);
		send_sample(CH_LX, 12'd0, 1'b1);
		send_sample(CH_LY, 12'd4095, 1'b1);
		send_sample(CH_LX, 12'd900, 1'b1);
		send_sample(CH_RX, 12'd300, 1'b1);
		send_sample(CH_RY, 12'd1500, 1'b1);

		// dpad off: held keys release ahead of the trigger event
		drain();
		c.mode = 7'd0;
		apply_config(c);
		send_sample(CH_TRIG_L, 12'd800, 1'b1);

		// zero divisors, min above max, LX inverted
		drain();
		apply_config(make_cfg(3000, 1000, 3000, 3500, 500, 500, 1, '0));
		send_sample(CH_LX, 12'd2000, 1'b1);
		send_sample(CH_LY, 12'd0, 1'b1);
		send_sample(CH_TRIG_L, 12'd0, 1'b1);

		// negative divisors, dead zone edges crossed
		drain();
		apply_config(make_cfg(2000, 500, 1000, 400, 3000, 1000, 0, {60{1'b1}}));
		send_sample(CH_RX, 12'd100, 1'b1);
		send_sample(CH_TRIG_R, 12'd2000, 1'b1);

		for (int p = 0; p < PHASES; p++) begin
			case (p)
			0: c = make_cfg(250, 1550, 790, 1010, 50, 800, 0, RESET_THR);
			3: c = make_cfg(0, 0, 0, 0, 0, 0, 0, '0);
			5: c = make_cfg(4095, 4095, 4095, 4095, 4095, 4095, 127, {60{1'b1}});
			6: c = rand_cfg(1'b1, 1'b0);
			9: c = rand_cfg(1'b1, 1'($urandom));
			default: c = rand_cfg(1'b0, p[0]);
			endcase
			run_phase(c, idle_mode_t'(p % 4), (p == 2) ? HOLD_OFF_CYCLES : 0);
		end

		drain();
		$display("Run covered %0d samples and %0d events under %0d register settings,",
			board.samples, board.events, settings);
		$display("with dpad toggling, sender and receiver idling and a long output hold-off.");
		if (board.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
